### rtl/core/bgl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgl_pkg
// Shared widths and transaction types for the binary gcd / lcm block.
// ----------------------------------------------------------------------------
package bgl_pkg;

    localparam int OPERAND_WIDTH = 64;
    localparam int FIELD_W       = 64;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0] word_t;
    typedef logic [OPERAND_WIDTH:0]   wide_t;

    typedef struct packed {
        logic [FIELD_W-1:0] operand_a;
        logic [FIELD_W-1:0] operand_b;
    } bgl_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] gcd_value;
        logic [FIELD_W-1:0] lcm_value;
        logic               lcm_overflow;
    } bgl_out_t;

    typedef struct packed {
        logic carry;
        logic zero;
    } alu_stat_t;

endpackage

### rtl/core/bgl_addsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgl_addsub
// Shared add / subtract unit with carry out and zero flag.
// ----------------------------------------------------------------------------
module bgl_addsub (
    input  bgl_pkg::wide_t     op_a,
    input  bgl_pkg::wide_t     op_b,
    input  logic               sub,
    output bgl_pkg::wide_t     res,
    output bgl_pkg::alu_stat_t stat
);
    import bgl_pkg::*;

    wide_t                  op_b_eff;
    logic [OPERAND_WIDTH+1:0] sum;

    always_comb
    begin
        op_b_eff   = sub ? ~op_b : op_b;
        sum        = {1'b0, op_a} + {1'b0, op_b_eff} + {{(OPERAND_WIDTH+1){1'b0}}, sub};
        res        = sum[OPERAND_WIDTH:0];
        stat.carry = sum[OPERAND_WIDTH+1];
        stat.zero  = (sum[OPERAND_WIDTH:0] == '0);
    end

endmodule

### rtl/core/binary_gcd_lcm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_gcd_lcm
// Greatest common divisor (binary method) and saturating least common
// multiple of two unsigned operands.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy stays high
// until the result is ready, and the result appears for exactly one cycle
// with done high, so the receiver must capture it in that cycle. An operand
// of zero is handled in the idle state, so busy never rises. Otherwise the
// time is data dependent: alignment halves both operands while both are
// even and then makes each odd, the gcd loop subtracts, swaps or shifts by a
// single bit, and then come restoring division and shift-add multiply, all
// on one shared adder.
// ----------------------------------------------------------------------------
module binary_gcd_lcm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bgl_pkg::bgl_in_t  operands,
    output logic              done,
    output bgl_pkg::bgl_out_t result
);
    import bgl_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ALIGN = 3'd1;
    localparam logic [2:0] ST_SUB   = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);

    logic [2:0]       state_reg, state_next;
    word_t            x_reg, x_next;
    word_t            y_reg, y_next;
    word_t            a_reg, a_next;
    word_t            b_reg, b_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             done_reg, done_next;
    word_t            gcd_reg, gcd_next;
    word_t            lcm_reg, lcm_next;
    logic             lovf_reg, lovf_next;

    wide_t     alu_a, alu_b, alu_res;
    logic      alu_sub;
    alu_stat_t alu_stat;

    word_t in_a, in_b;
    logic  ovf_final;

    assign in_a = operands.operand_a[OPERAND_WIDTH-1:0];
    assign in_b = operands.operand_b[OPERAND_WIDTH-1:0];

    bgl_addsub u_addsub (
        .op_a (alu_a),
        .op_b (alu_b),
        .sub  (alu_sub),
        .res  (alu_res),
        .stat (alu_stat)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_DIV:
            begin
                alu_a   = {x_reg, a_reg[OPERAND_WIDTH-1]};
                alu_b   = {1'b0, y_reg};
                alu_sub = 1'b1;
            end
            ST_MUL:
            begin
                alu_a   = {x_reg, 1'b0};
                alu_b   = a_reg[OPERAND_WIDTH-1] ? {1'b0, b_reg} : '0;
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a   = {1'b0, x_reg};
                alu_b   = {1'b0, y_reg};
                alu_sub = 1'b1;
            end
        endcase
    end

    assign ovf_final = ovf_reg | alu_stat.carry | alu_res[OPERAND_WIDTH];

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        done_next  = 1'b0;
        gcd_next   = gcd_reg;
        lcm_next   = lcm_reg;
        lovf_next  = lovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (in_a == '0 || in_b == '0)
                    begin
                        gcd_next  = in_a | in_b;
                        lcm_next  = '0;
                        lovf_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        x_next     = in_a;
                        y_next     = in_b;
                        a_next     = in_a;
                        b_next     = in_b;
                        k_next     = '0;
                        state_next = ST_ALIGN;
                    end
                end
            end
            ST_ALIGN:
            begin
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    if (!x_reg[0])
                    begin
                        x_next = x_reg >> 1;
                    end
                    if (!y_reg[0])
                    begin
                        y_next = y_reg >> 1;
                    end
                    if (x_reg[0] && y_reg[0])
                    begin
                        state_next = ST_SUB;
                    end
                end
            end
            ST_SUB:
            begin
                priority if (!alu_stat.carry)
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
                else if (alu_stat.zero)
                begin
                    y_next     = y_reg << k_reg;
                    x_next     = '0;
                    cnt_next   = CNT_LAST;
                    state_next = ST_DIV;
                end
                else
                begin
                    x_next     = alu_res[OPERAND_WIDTH-1:0];
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                x_next = x_reg >> 1;
                if (x_reg[1])
                begin
                    state_next = ST_SUB;
                end
            end
            ST_DIV:
            begin
                if (alu_stat.carry)
                begin
                    x_next = alu_res[OPERAND_WIDTH-1:0];
                end
                else
                begin
                    x_next = alu_a[OPERAND_WIDTH-1:0];
                end
                a_next   = {a_reg[OPERAND_WIDTH-2:0], alu_stat.carry};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    x_next     = '0;
                    ovf_next   = 1'b0;
                    cnt_next   = CNT_LAST;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                x_next   = alu_res[OPERAND_WIDTH-1:0];
                a_next   = a_reg << 1;
                ovf_next = ovf_final;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    gcd_next   = y_reg;
                    lcm_next   = ovf_final ? '1 : alu_res[OPERAND_WIDTH-1:0];
                    lovf_next  = ovf_final;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            k_reg     <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        gcd_reg  <= gcd_next;
        lcm_reg  <= lcm_next;
        lovf_reg <= lovf_next;
    end

    assign busy                = (state_reg != ST_IDLE);
    assign done                = done_reg;
    assign result.gcd_value    = FIELD_W'(gcd_reg);
    assign result.lcm_value    = FIELD_W'(lcm_reg);
    assign result.lcm_overflow = lovf_reg;

endmodule

### sim/bgl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgl_checker
// Watches the command and result channels of binary_gcd_lcm, predicts the
// gcd, the saturating lcm and the overflow flag of every accepted
// transaction, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module bgl_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  bgl_pkg::bgl_in_t  operands,
    input  logic              done,
    input  bgl_pkg::bgl_out_t result,
    output int                fail_count,
    output int                in_flight
);
    import bgl_pkg::*;

    bgl_out_t expected_results[$];
    bgl_out_t oldest;
    int       mismatches = 0;

    // Euclid for the gcd, an exact double-width product for the lcm.
    function automatic bgl_out_t gcd_lcm_of(input bgl_in_t op);
        word_t                        a;
        word_t                        b;
        word_t                        x;
        word_t                        y;
        word_t                        r;
        word_t                        all_ones;
        logic [2*OPERAND_WIDTH-1:0]   product;
        bgl_out_t                     res;
        all_ones = '1;
        a = op.operand_a[OPERAND_WIDTH-1:0];
        b = op.operand_b[OPERAND_WIDTH-1:0];
        x = a;
        y = b;
        while (y != '0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        res = '0;
        res.gcd_value = x;
        if (a != '0 && b != '0)
        begin
            product = {{OPERAND_WIDTH{1'b0}}, a / x} * {{OPERAND_WIDTH{1'b0}}, b};
            if (product > {{OPERAND_WIDTH{1'b0}}, all_ones})
            begin
                res.lcm_value    = all_ones;
                res.lcm_overflow = 1'b1;
            end
            else
            begin
                res.lcm_value = product[OPERAND_WIDTH-1:0];
            end
        end
        return res;
    endfunction

    task automatic report(input string what, input logic [FIELD_W-1:0] got,
                          input logic [FIELD_W-1:0] want);
        $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    report("result with no transaction pending", result.gcd_value, '0);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (result.gcd_value !== oldest.gcd_value)
                        report("gcd_value", result.gcd_value, oldest.gcd_value);
                    if (result.lcm_value !== oldest.lcm_value)
                        report("lcm_value", result.lcm_value, oldest.lcm_value);
                    if (result.lcm_overflow !== oldest.lcm_overflow)
                        report("lcm_overflow", FIELD_W'(result.lcm_overflow),
                               FIELD_W'(oldest.lcm_overflow));
                end
            end
            if (start && !busy)
                expected_results.push_back(gcd_lcm_of(operands));
        end
        in_flight  <= expected_results.size();
        fail_count <= mismatches;
    end

endmodule

### sim/tb_binary_gcd_lcm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_gcd_lcm
// Drives binary_gcd_lcm with directed corner pairs (zeros, all ones, powers
// of two, lcm exactly at and just past the top of the range) and then with
// random pairs that share factors, scaled by powers of two or of mixed sizes,
// with random gaps between commands. A checker beside the block predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_binary_gcd_lcm;
    import bgl_pkg::*;

    localparam int RANDOM_PAIRS = 700;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int TAIL_CYCLES  = 50;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    bgl_in_t  operands;
    logic     done;
    bgl_out_t result;
    int       mismatch_total;
    int       results_pending;
    int       cycles = 0;

    binary_gcd_lcm u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    bgl_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operands   (operands),
        .done       (done),
        .result     (result),
        .fail_count (mismatch_total),
        .in_flight  (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("binary_gcd_lcm: mismatch");
            $finish;
        end
    end

    function automatic word_t rand_bits(input int keep);
        word_t x;
        x = {$urandom, $urandom};
        return x >> (OPERAND_WIDTH - keep);
    endfunction

    // Hold start until the transaction is taken.
    task automatic send_pair(input word_t a, input word_t b, input bit may_idle);
        bgl_in_t item;
        if (may_idle)
        begin
            while ($urandom_range(0, 99) < 38)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        item.operand_a = a;
        item.operand_b = b;
        operands <= item;
        start    <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    initial
    begin
        word_t a;
        word_t b;
        word_t g;
        word_t t;
        rst_n    = 1'b0;
        start    = 1'b0;
        operands = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pair(64'h0, 64'h0, 1'b1);
        send_pair(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0);
        send_pair(64'h1, 64'h1, 1'b0);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_pair(64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 1'b1);
        send_pair(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0);
        send_pair(64'h8000_0000_0000_0000, 64'h1, 1'b1);
        send_pair(64'h8000_0000_0000_0000, 64'h3, 1'b0);
        send_pair(64'h2, 64'h8000_0000_0000_0000, 1'b1);
        send_pair(64'h1_0000_0000, 64'hFFFF_FFFF, 1'b0);
        send_pair(64'h1_0000_0001, 64'hFFFF_FFFF, 1'b1);
        send_pair(64'h1_0000_0001, 64'h1_0000_0003, 1'b0);
        send_pair(64'd12200160415121876738, 64'd7540113804746346429, 1'b1);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        send_pair(64'h8000_0000_0000_0001, 64'h0, 1'b1);
        send_pair(64'd12, 64'd18, 1'b0);
        send_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
        send_pair(64'h300_0000_0000, 64'h90_0000, 1'b0);

        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    a = rand_bits(64);
                    b = rand_bits(64);
                end
                2, 3:
                begin
                    a = rand_bits($urandom_range(1, 32));
                    b = rand_bits($urandom_range(1, 32));
                end
                4, 5, 6:
                begin
                    g = rand_bits($urandom_range(1, 24));
                    a = g * rand_bits($urandom_range(1, 24));
                    b = g * rand_bits($urandom_range(1, 24));
                end
                7:
                begin
                    a = rand_bits($urandom_range(1, 40)) << $urandom_range(0, 24);
                    b = rand_bits($urandom_range(1, 40)) << $urandom_range(0, 24);
                end
                8:
                begin
                    a = rand_bits($urandom_range(1, 64));
                    b = a * word_t'($urandom_range(1, 1000));
                end
                default:
                begin
                    a = $urandom_range(0, 1) ? '0 : rand_bits($urandom_range(1, 64));
                    b = $urandom_range(0, 1) ? '0 : rand_bits($urandom_range(1, 64));
                end
            endcase
            if ($urandom_range(0, 1))
            begin
                t = a;
                a = b;
                b = t;
            end
            send_pair(a, b, !(n >= 250 && n < 400));
        end
        start <= 1'b0;
        @(posedge clk);

        while (results_pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_total == 0)
        begin
            $display("binary_gcd_lcm: match");
        end
        else
        begin
            $display("binary_gcd_lcm: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/bgl_pkg.sv
rtl/core/bgl_addsub.sv
rtl/core/binary_gcd_lcm.sv
sim/bgl_checker.sv
sim/tb_binary_gcd_lcm.sv
